### rtl/eds_pkg.sv
// Shared types and constants for the elevator dispatch scorer.
// Used by every module in rtl/; depends on nothing else.
package eds_pkg;

  localparam int MAX_CARS   = 16;
  localparam int FLOOR_BITS = 8;

  localparam int FLOOR_W = 8;
  localparam int IDX_W   = 4;
  localparam int HEAD_W  = 2;
  localparam int SCORE_W = 10;
  // Signed width that holds every intermediate travel cost.
  localparam int COST_W  = 12;

  localparam int FLOOR_KEEP = (FLOOR_BITS > FLOOR_W) ? FLOOR_W : FLOOR_BITS;
  localparam logic [FLOOR_W-1:0] FLOOR_MASK = FLOOR_W'((1 << FLOOR_KEEP) - 1);

  localparam logic [SCORE_W-1:0] CEIL_RESET = SCORE_W'(100);

  localparam logic [HEAD_W-1:0] HEAD_DOWN = 2'd0;
  localparam logic [HEAD_W-1:0] HEAD_UP   = 2'd1;

  typedef struct packed {
    logic load;       // capture the accepted request
    logic mod_start;  // start room mod capacity
    logic score;      // register the clamped score
    logic update;     // compare against the bound and keep
    logic emit;       // load the result register and restart the run
  } eds_cmd_t;

  typedef struct packed {
    logic eligible;
    logic last;
    logic mod_done;
  } eds_sts_t;

endpackage

### rtl/elevator_dispatch_scorer_core.sv
// Nearest-car dispatch scorer, top level.
// Depends on eds_pkg, eds_ctrl, eds_datapath and eds_mod.
//
// Usage: for one passenger request, send one request per elevator car on
// the input channel (in_valid/in_ready), marking the final car with
// last_car. Each eligible car is scored as (room mod capacity) plus a
// direction-dependent travel distance; the lowest score strictly below
// score_ceiling wins, ties going to the earlier car. After the last car
// one result (found, chosen_car, chosen_score) appears on the output
// channel (out_valid/out_ready).
// Timing: a request is taken only while the controller is idle, so the next
// request waits until the previous one finishes; an eligible car also runs
// through the 8-step remainder unit. A result is valid the cycle after the
// last request finishes.
// Stall: the result sits in an output register, so new requests are taken
// while it waits; a last request that completes while the register is
// still full holds until the receiver takes the old result.
// Reset: score_ceiling returns to 100, the run restarts and no result is
// pending. cfg_write loads score_ceiling; write it only while idle.
module elevator_dispatch_scorer_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [eds_pkg::SCORE_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [eds_pkg::FLOOR_W-1:0] request_start,
  input  logic [eds_pkg::FLOOR_W-1:0] request_end,
  input  logic [eds_pkg::IDX_W-1:0]   car_index,
  input  logic [eds_pkg::FLOOR_W-1:0] car_lowest,
  input  logic [eds_pkg::FLOOR_W-1:0] car_highest,
  input  logic [eds_pkg::FLOOR_W-1:0] car_capacity,
  input  logic [eds_pkg::FLOOR_W-1:0] car_floor,
  input  logic [eds_pkg::HEAD_W-1:0]  car_heading,
  input  logic [eds_pkg::FLOOR_W-1:0] car_room,
  input  logic                        status_valid,
  input  logic                        last_car,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        found,
  output logic [eds_pkg::IDX_W-1:0]   chosen_car,
  output logic [eds_pkg::SCORE_W-1:0] chosen_score
);
  import eds_pkg::*;

  eds_cmd_t cmd;
  eds_sts_t sts;

  eds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  eds_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .request_start (request_start),
    .request_end   (request_end),
    .car_index     (car_index),
    .car_lowest    (car_lowest),
    .car_highest   (car_highest),
    .car_capacity  (car_capacity),
    .car_floor     (car_floor),
    .car_heading   (car_heading),
    .car_room      (car_room),
    .status_valid  (status_valid),
    .last_car      (last_car),
    .found         (found),
    .chosen_car    (chosen_car),
    .chosen_score  (chosen_score)
  );

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  // never overwrite a result the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  a_none_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> chosen_car == '0)
    else $error("chosen_car nonzero with no car found");

  a_mod_only_eligible: assert property (@(posedge clk) disable iff (rst)
    cmd.mod_start |-> sts.eligible)
    else $error("remainder started for an ineligible car");

endmodule

### rtl/eds_mod.sv
// Iterative remainder unit: one restoring step per cycle.
// Depends on eds_pkg.
module eds_mod (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [eds_pkg::FLOOR_W-1:0] dividend,
  input  logic [eds_pkg::FLOOR_W-1:0] divisor,
  output logic                        done,
  output logic [eds_pkg::FLOOR_W-1:0] rem
);
  import eds_pkg::*;

  localparam int CNT_W = $clog2(FLOOR_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(FLOOR_W - 1);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [FLOOR_W-1:0] dvd;
  logic [FLOOR_W:0]   trial;
  logic [FLOOR_W:0]   diff;

  assign trial = {rem, dvd[FLOOR_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign done  = busy && (cnt == LAST_STEP);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == LAST_STEP) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
    end else if (busy) begin
      dvd <= dvd << 1;
      // restore when the trial is below the divisor
      if (diff[FLOOR_W]) begin
        rem <= trial[FLOOR_W-1:0];
      end else begin
        rem <= diff[FLOOR_W-1:0];
      end
    end
  end

endmodule

### rtl/eds_datapath.sv
// Datapath: request registers, eligibility, travel cost, running best
// and result register. Depends on eds_pkg and eds_mod.
module eds_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  eds_pkg::eds_cmd_t           cmd,
  output eds_pkg::eds_sts_t           sts,
  input  logic                        cfg_write,
  input  logic [eds_pkg::SCORE_W-1:0] cfg_data,
  input  logic [eds_pkg::FLOOR_W-1:0] request_start,
  input  logic [eds_pkg::FLOOR_W-1:0] request_end,
  input  logic [eds_pkg::IDX_W-1:0]   car_index,
  input  logic [eds_pkg::FLOOR_W-1:0] car_lowest,
  input  logic [eds_pkg::FLOOR_W-1:0] car_highest,
  input  logic [eds_pkg::FLOOR_W-1:0] car_capacity,
  input  logic [eds_pkg::FLOOR_W-1:0] car_floor,
  input  logic [eds_pkg::HEAD_W-1:0]  car_heading,
  input  logic [eds_pkg::FLOOR_W-1:0] car_room,
  input  logic                        status_valid,
  input  logic                        last_car,
  output logic                        found,
  output logic [eds_pkg::IDX_W-1:0]   chosen_car,
  output logic [eds_pkg::SCORE_W-1:0] chosen_score
);
  import eds_pkg::*;

  logic [FLOOR_W-1:0] f_start, f_end, f_lo, f_hi, f_cap, f_floor, f_room;
  logic [IDX_W-1:0]   f_idx;
  logic [HEAD_W-1:0]  f_head;
  logic               f_valid, f_last;

  logic [SCORE_W-1:0] ceiling;
  logic [SCORE_W-1:0] best_score;
  logic [IDX_W-1:0]   best_car;
  logic               have_best;
  logic [SCORE_W-1:0] score;
  logic [SCORE_W-1:0] bound;

  logic [FLOOR_W-1:0] m;
  logic               mod_done;

  logic signed [COST_W-1:0] s_x, c_x, lo_x, hi_x, m_x, raw;
  logic                     going_up;
  logic [SCORE_W-1:0]       score_next;

  eds_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mod_start),
    .dividend (f_room),
    .divisor  (f_cap),
    .done     (mod_done),
    .rem      (m)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      f_start <= request_start & FLOOR_MASK;
      f_end   <= request_end & FLOOR_MASK;
      f_idx   <= car_index;
      f_lo    <= car_lowest & FLOOR_MASK;
      f_hi    <= car_highest & FLOOR_MASK;
      f_cap   <= car_capacity;
      f_floor <= car_floor & FLOOR_MASK;
      f_head  <= car_heading;
      f_room  <= car_room;
      f_valid <= status_valid;
      f_last  <= last_car;
    end
  end

  assign sts.eligible = f_valid && ({1'b0, f_idx} < (IDX_W+1)'(MAX_CARS)) &&
                        (f_lo <= f_start) && (f_start <= f_hi) &&
                        (f_lo <= f_end) && (f_end <= f_hi) &&
                        (f_room != '0) && (f_cap != '0);
  assign sts.last     = f_last;
  assign sts.mod_done = mod_done;

  assign s_x  = $signed({{(COST_W-FLOOR_W){1'b0}}, f_start});
  assign c_x  = $signed({{(COST_W-FLOOR_W){1'b0}}, f_floor});
  assign lo_x = $signed({{(COST_W-FLOOR_W){1'b0}}, f_lo});
  assign hi_x = $signed({{(COST_W-FLOOR_W){1'b0}}, f_hi});
  assign m_x  = $signed({{(COST_W-FLOOR_W){1'b0}}, m});
  assign going_up = f_start < f_end;

  always_comb begin
    if (!going_up && (c_x >= s_x)) begin
      if (f_head == HEAD_DOWN) begin
        raw = m_x + c_x - s_x;
      end else begin
        raw = m_x + ((hi_x - c_x) <<< 1) + (c_x - s_x);
      end
    end else if (going_up && (c_x <= s_x)) begin
      if (f_head == HEAD_UP) begin
        raw = m_x + s_x - c_x;
      end else begin
        raw = m_x + ((c_x - lo_x) <<< 1) + (s_x - c_x);
      end
    end else if (f_head == HEAD_DOWN) begin
      raw = m_x + (c_x - lo_x) + (s_x - lo_x);
    end else begin
      raw = m_x + (hi_x - c_x) + hi_x + (s_x - lo_x);
    end
  end

  // clamp a negative cost (car outside its own range) to zero
  assign score_next = raw[COST_W-1] ? '0 : raw[SCORE_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.score) begin
      score <= score_next;
    end
  end

  assign bound = have_best ? best_score : ceiling;

  always_ff @(posedge clk) begin
    if (rst) begin
      ceiling <= CEIL_RESET;
    end else if (cfg_write) begin
      ceiling <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_best  <= 1'b0;
      best_car   <= '0;
      best_score <= CEIL_RESET;
    end else if (cmd.emit) begin
      have_best <= 1'b0;
      best_car  <= '0;
    end else if (cmd.update && (score < bound)) begin
      have_best  <= 1'b1;
      best_car   <= f_idx;
      best_score <= score;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      found        <= have_best;
      chosen_car   <= have_best ? best_car : '0;
      chosen_score <= bound;
    end
  end

endmodule

### rtl/eds_ctrl.sv
// Controller: sequences one request through check and, when eligible, remainder,
// scoring and update, and owns both handshakes. Depends on eds_pkg.
module eds_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  eds_pkg::eds_sts_t sts,
  output eds_pkg::eds_cmd_t cmd
);
  import eds_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CHECK  = 6'b000010,
    S_MOD    = 6'b000100,
    S_SCORE  = 6'b001000,
    S_UPDATE = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.load      = in_valid && in_ready;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.eligible) begin
          cmd.mod_start = 1'b1;
          state_next    = S_MOD;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_MOD: begin
        if (sts.mod_done) begin
          state_next = S_SCORE;
        end
      end
      S_SCORE: begin
        cmd.score  = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        // hold the final request until the result register frees up
        if (!sts.last) begin
          state_next = S_IDLE;
        end else if (slot_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
